// ===== hw/rtl/mbp_pkg.sv =====
// ----------------------------------------------------------------------------
// mbp_pkg
// Shared types and codes of the rectangle packer: datapath commands,
// datapath status, request actions and configuration register indexes.
// ----------------------------------------------------------------------------
`default_nettype none

package mbp_pkg;

  // configuration register indexes
  localparam logic [1:0] CFG_ATLAS_W = 2'd0;
  localparam logic [1:0] CFG_ATLAS_H = 2'd1;
  localparam logic [1:0] CFG_PAD     = 2'd2;

  // request actions
  localparam logic ACT_ALLOC = 1'b0;
  localparam logic ACT_CLEAR = 1'b1;

  // width of the fixed item fields
  localparam int FW = 15;
  localparam int PW = 8;

  // coordinate width of a stored free rect
  localparam int COORD_BITS = 15;

  // command issued by the controller for one cycle
  typedef enum logic [4:0] {
    CMD_NOP,
    CMD_CLEAR,
    CMD_START,
    CMD_RD_I,
    CMD_RD_J,
    CMD_RD_LAST,
    CMD_RD_S,
    CMD_SCAN,
    CMD_UNION,
    CMD_PASSA,
    CMD_IRST,
    CMD_FLAT,
    CMD_PIECE,
    CMD_CPINIT,
    CMD_COPY,
    CMD_PRINIT,
    CMD_PR_R,
    CMD_JINC,
    CMD_SWAP,
    CMD_KINIT,
    CMD_COMPACT,
    CMD_PRNEXT,
    CMD_EMIT_NONE,
    CMD_EMIT_OVF,
    CMD_EMIT_OK
  } cmd_t;

  // datapath status seen by the controller
  typedef struct packed {
    logic i_lt_cnt;
    logic j_lt_cnt;
    logic ok;
    logic best_vld;
    logic hit;
    logic last_piece;
    logic out_full;
  } status_t;

endpackage

`default_nettype wire

// ===== hw/rtl/mbp_ifs.sv =====
// ----------------------------------------------------------------------------
// mbp channel interfaces
// Request, result and configuration channels of the packer.
// ----------------------------------------------------------------------------
`default_nettype none

interface mbp_in_if;
  logic        valid;
  logic        ready;
  logic        action;
  logic [14:0] req_width;
  logic [14:0] req_height;
  modport source (output valid, action, req_width, req_height, input ready);
  modport sink   (input valid, action, req_width, req_height, output ready);
endinterface

interface mbp_out_if;
  logic        valid;
  logic        ready;
  logic        found;
  logic [14:0] place_x;
  logic [14:0] place_y;
  logic        overflow;
  modport source (output valid, found, place_x, place_y, overflow, input ready);
  modport sink   (input valid, found, place_x, place_y, overflow, output ready);
endinterface

interface mbp_cfg_if;
  logic        valid;
  logic        ready;
  logic [1:0]  index;
  logic [14:0] data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/mbp_ctrl.sv =====
// ----------------------------------------------------------------------------
// mbp_ctrl
// Sequencer of the packer: clear, scan, untouched-rect, split, copy and prune passes, result beat.
// ----------------------------------------------------------------------------
`default_nettype none

module mbp_ctrl (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_vld,
  input  wire logic             in_action,
  output logic                  in_rdy,
  input  wire mbp_pkg::status_t st,
  output mbp_pkg::cmd_t         cmd
);

  typedef enum logic [4:0] {
    S_INIT, S_IDLE, S_CLR, S_SCAN, S_SCAN_EV, S_UNION, S_A, S_A_EV,
    S_B, S_B_LAT, S_B_PC, S_CP_INIT, S_COPY, S_COPY_WR, S_PR, S_PR_R,
    S_PR_J, S_PR_IN, S_PR_SW, S_PR_K, S_PR_C, S_EMIT
  } state_t;

  state_t        state_r, state_nxt;
  mbp_pkg::cmd_t emit_r, emit_nxt;

  assign in_rdy = (state_r == S_IDLE);

  // next state and command decode
  always_comb begin
    state_nxt = state_r;
    emit_nxt  = emit_r;
    cmd       = mbp_pkg::CMD_NOP;
    case (state_r)
      S_INIT: begin
        cmd       = mbp_pkg::CMD_CLEAR;
        state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (in_vld) begin
          cmd       = mbp_pkg::CMD_START;
          state_nxt = (in_action == mbp_pkg::ACT_CLEAR) ? S_CLR : S_SCAN;
        end
      end
      S_CLR: begin
        cmd       = mbp_pkg::CMD_CLEAR;
        emit_nxt  = mbp_pkg::CMD_EMIT_NONE;
        state_nxt = S_EMIT;
      end
      S_SCAN: begin
        if (st.i_lt_cnt) begin
          cmd       = mbp_pkg::CMD_RD_I;
          state_nxt = S_SCAN_EV;
        end else if (st.best_vld) begin
          state_nxt = S_UNION;
        end else begin
          emit_nxt  = mbp_pkg::CMD_EMIT_NONE;
          state_nxt = S_EMIT;
        end
      end
      S_SCAN_EV: begin
        cmd       = mbp_pkg::CMD_SCAN;
        state_nxt = S_SCAN;
      end
      S_UNION: begin
        cmd       = mbp_pkg::CMD_UNION;
        state_nxt = S_A;
      end
      S_A: begin
        if (st.i_lt_cnt && st.ok) begin
          cmd       = mbp_pkg::CMD_RD_I;
          state_nxt = S_A_EV;
        end else begin
          cmd       = mbp_pkg::CMD_IRST;
          state_nxt = S_B;
        end
      end
      S_A_EV: begin
        cmd       = mbp_pkg::CMD_PASSA;
        state_nxt = S_A;
      end
      S_B: begin
        if (st.i_lt_cnt && st.ok) begin
          cmd       = mbp_pkg::CMD_RD_I;
          state_nxt = S_B_LAT;
        end else if (st.ok) begin
          state_nxt = S_CP_INIT;
        end else begin
          emit_nxt  = mbp_pkg::CMD_EMIT_OVF;
          state_nxt = S_EMIT;
        end
      end
      S_B_LAT: begin
        cmd       = mbp_pkg::CMD_FLAT;
        state_nxt = S_B_PC;
      end
      S_B_PC: begin
        cmd = mbp_pkg::CMD_PIECE;
        if (st.last_piece) state_nxt = S_B;
      end
      S_CP_INIT: begin
        cmd       = mbp_pkg::CMD_CPINIT;
        state_nxt = S_COPY;
      end
      S_COPY: begin
        if (st.i_lt_cnt) begin
          cmd       = mbp_pkg::CMD_RD_S;
          state_nxt = S_COPY_WR;
        end else begin
          cmd       = mbp_pkg::CMD_PRINIT;
          state_nxt = S_PR;
        end
      end
      S_COPY_WR: begin
        cmd       = mbp_pkg::CMD_COPY;
        state_nxt = S_COPY;
      end
      S_PR: begin
        if (st.i_lt_cnt) begin
          cmd       = mbp_pkg::CMD_RD_I;
          state_nxt = S_PR_R;
        end else begin
          emit_nxt  = mbp_pkg::CMD_EMIT_OK;
          state_nxt = S_EMIT;
        end
      end
      S_PR_R: begin
        cmd       = mbp_pkg::CMD_PR_R;
        state_nxt = S_PR_J;
      end
      S_PR_J: begin
        if (st.j_lt_cnt) begin
          cmd       = mbp_pkg::CMD_RD_J;
          state_nxt = S_PR_IN;
        end else begin
          cmd       = mbp_pkg::CMD_KINIT;
          state_nxt = S_PR_K;
        end
      end
      S_PR_IN: begin
        // contained in a later rect: pull the last entry into this slot
        if (st.hit) begin
          cmd       = mbp_pkg::CMD_RD_LAST;
          state_nxt = S_PR_SW;
        end else begin
          cmd       = mbp_pkg::CMD_JINC;
          state_nxt = S_PR_J;
        end
      end
      S_PR_SW: begin
        cmd       = mbp_pkg::CMD_SWAP;
        state_nxt = S_PR;
      end
      S_PR_K: begin
        if (st.j_lt_cnt) begin
          cmd       = mbp_pkg::CMD_RD_J;
          state_nxt = S_PR_C;
        end else begin
          cmd       = mbp_pkg::CMD_PRNEXT;
          state_nxt = S_PR;
        end
      end
      S_PR_C: begin
        cmd       = mbp_pkg::CMD_COMPACT;
        state_nxt = S_PR_K;
      end
      S_EMIT: begin
        if (!st.out_full) begin
          cmd       = emit_r;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_INIT;
    endcase
  end

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_INIT;
      emit_r  <= mbp_pkg::CMD_EMIT_NONE;
    end else begin
      state_r <= state_nxt;
      emit_r  <= emit_nxt;
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/mbp_dp.sv =====
// ----------------------------------------------------------------------------
// mbp_dp
// Datapath of the packer: free rect table, split staging table, counters,
// fit and overlap logic, configuration registers and result register.
// ----------------------------------------------------------------------------
`default_nettype none

module mbp_dp #(
  parameter int MAX_FREE = 64
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire mbp_pkg::cmd_t    cmd,
  output mbp_pkg::status_t      st,
  input  wire logic [14:0]      in_req_w,
  input  wire logic [14:0]      in_req_h,
  input  wire logic             cfg_we,
  input  wire logic [1:0]       cfg_idx,
  input  wire logic [14:0]      cfg_wdata,
  output logic                  out_vld,
  input  wire logic             out_rdy,
  output logic                  out_found,
  output logic [14:0]           out_x,
  output logic [14:0]           out_y,
  output logic                  out_ovf
);

  localparam int CB = mbp_pkg::COORD_BITS;
  localparam int EW = 4 * CB;
  localparam int AW = $clog2(MAX_FREE);
  localparam int NW = $clog2(MAX_FREE + 1);
  localparam int XW = ((CB > mbp_pkg::FW) ? CB : mbp_pkg::FW) + 2;

  // entry layout: {left, top, width, height}
  function automatic logic [XW-1:0] f_l(input logic [EW-1:0] e);
    f_l = XW'(e[4*CB-1:3*CB]);
  endfunction
  function automatic logic [XW-1:0] f_t(input logic [EW-1:0] e);
    f_t = XW'(e[3*CB-1:2*CB]);
  endfunction
  function automatic logic [XW-1:0] f_w(input logic [EW-1:0] e);
    f_w = XW'(e[2*CB-1:CB]);
  endfunction
  function automatic logic [XW-1:0] f_h(input logic [EW-1:0] e);
    f_h = XW'(e[CB-1:0]);
  endfunction

  // b lies within a
  function automatic logic holds(input logic [EW-1:0] a, input logic [EW-1:0] b);
    holds = (f_l(b) >= f_l(a)) && (f_t(b) >= f_t(a)) &&
            (f_l(b) + f_w(b) <= f_l(a) + f_w(a)) &&
            (f_t(b) + f_h(b) <= f_t(a) + f_h(a));
  endfunction

  // configuration
  logic [14:0] aw_r, ah_r;
  logic [7:0]  pad_r;

  // tables
  logic [EW-1:0] free_mem [MAX_FREE];
  logic [EW-1:0] scr_mem  [MAX_FREE];
  logic [EW-1:0] rdata_r, srdata_r;

  // working registers
  logic [NW-1:0] i_r, i_nxt, j_r, j_nxt, k_r, k_nxt, n_r, n_nxt, cnt_r, cnt_nxt;
  logic [14:0]   rw_r, rw_nxt, rh_r, rh_nxt;
  logic          best_vld_r, best_vld_nxt, ok_r, ok_nxt;
  logic [XW-1:0] min_fit_r, min_fit_nxt;
  logic [CB-1:0] bl_r, bl_nxt, bt_r, bt_nxt;
  logic [XW-1:0] ul_r, ul_nxt, ut_r, ut_nxt, ur_r, ur_nxt, ub_r, ub_nxt;
  logic [EW-1:0] f_r, f_nxt, r_r, r_nxt;
  logic [1:0]    pc_r, pc_nxt;
  logic          ovld_r, ovld_nxt, ofound_r, ofound_nxt, oovf_r, oovf_nxt;
  logic [CB-1:0] ox_r, ox_nxt, oy_r, oy_nxt;

  // memory port controls
  logic          fw_en, sw_en;
  logic [AW-1:0] fw_addr, fr_addr, sw_addr;
  logic [EW-1:0] fw_data, sw_data;
  logic [NW-1:0] last_idx;

  // fit and overlap terms
  logic [XW-1:0] dw, dh, fit;
  logic          fits, ovl_rd, ovl_f, stage_en, full;
  logic [XW-1:0] fr_x, fb_y, pr_x, pb_y;
  logic [EW-1:0] piece;
  logic [31:0]   x_ext, y_ext;

  assign last_idx = cnt_r - NW'(1);
  assign full     = (n_r >= NW'(MAX_FREE));

  // fit of the rect on the read port
  always_comb begin
    fits = (f_w(rdata_r) >= XW'(rw_r)) && (f_h(rdata_r) >= XW'(rh_r));
    dw   = f_w(rdata_r) - XW'(rw_r);
    dh   = f_h(rdata_r) - XW'(rh_r);
    fit  = (dw < dh) ? dw : dh;
  end

  // overlap of the read rect and of the latched rect with the placement
  always_comb begin
    logic [XW-1:0] lo_x, hi_x, lo_y, hi_y;
    pr_x = f_l(rdata_r) + f_w(rdata_r);
    pb_y = f_t(rdata_r) + f_h(rdata_r);
    lo_x = (f_l(rdata_r) > ul_r) ? f_l(rdata_r) : ul_r;
    hi_x = (pr_x < ur_r) ? pr_x : ur_r;
    lo_y = (f_t(rdata_r) > ut_r) ? f_t(rdata_r) : ut_r;
    hi_y = (pb_y < ub_r) ? pb_y : ub_r;
    ovl_rd = (lo_x < hi_x) && (lo_y < hi_y);
    fr_x = f_l(f_r) + f_w(f_r);
    fb_y = f_t(f_r) + f_h(f_r);
    lo_x = (f_l(f_r) > ul_r) ? f_l(f_r) : ul_r;
    hi_x = (fr_x < ur_r) ? fr_x : ur_r;
    lo_y = (f_t(f_r) > ut_r) ? f_t(f_r) : ut_r;
    hi_y = (fb_y < ub_r) ? fb_y : ub_r;
    ovl_f = (lo_x < hi_x) && (lo_y < hi_y);
  end

  // one of the four split pieces of the latched rect
  always_comb begin
    logic hband, vband;
    hband    = (ul_r < fr_x) && (ur_r > f_l(f_r));
    vband    = (ut_r < fb_y) && (ub_r > f_t(f_r));
    piece    = f_r;
    stage_en = 1'b0;
    case (pc_r)
      2'd0: begin
        stage_en = ovl_f && hband && (ut_r > f_t(f_r)) && (ut_r < fb_y);
        piece[CB-1:0] = CB'(ut_r - f_t(f_r));
      end
      2'd1: begin
        stage_en = ovl_f && hband && (ub_r < fb_y);
        piece[3*CB-1:2*CB] = CB'(ub_r);
        piece[CB-1:0]      = CB'(fb_y - ub_r);
      end
      2'd2: begin
        stage_en = ovl_f && vband && (ul_r > f_l(f_r)) && (ul_r < fr_x);
        piece[2*CB-1:CB] = CB'(ul_r - f_l(f_r));
      end
      default: begin
        stage_en = ovl_f && vband && (ur_r < fr_x);
        piece[4*CB-1:3*CB] = CB'(ur_r);
        piece[2*CB-1:CB]   = CB'(fr_x - ur_r);
      end
    endcase
  end

  // command execution
  always_comb begin
    i_nxt = i_r; j_nxt = j_r; k_nxt = k_r; n_nxt = n_r; cnt_nxt = cnt_r;
    rw_nxt = rw_r; rh_nxt = rh_r;
    best_vld_nxt = best_vld_r; min_fit_nxt = min_fit_r;
    bl_nxt = bl_r; bt_nxt = bt_r; ok_nxt = ok_r;
    ul_nxt = ul_r; ut_nxt = ut_r; ur_nxt = ur_r; ub_nxt = ub_r;
    f_nxt = f_r; r_nxt = r_r; pc_nxt = pc_r;
    ovld_nxt = ovld_r; ofound_nxt = ofound_r; oovf_nxt = oovf_r;
    ox_nxt = ox_r; oy_nxt = oy_r;
    fw_en = 1'b0; fw_addr = i_r[AW-1:0]; fw_data = rdata_r;
    sw_en = 1'b0; sw_addr = n_r[AW-1:0]; sw_data = rdata_r;
    fr_addr = i_r[AW-1:0];

    if (ovld_r && out_rdy) ovld_nxt = 1'b0;

    case (cmd)
      mbp_pkg::CMD_CLEAR: begin
        cnt_nxt = NW'((aw_r != 15'd0) && (ah_r != 15'd0));
        fw_en   = 1'b1;
        fw_addr = '0;
        fw_data = {CB'(0), CB'(0), CB'(aw_r), CB'(ah_r)};
      end
      mbp_pkg::CMD_START: begin
        rw_nxt = in_req_w; rh_nxt = in_req_h;
        i_nxt = '0; best_vld_nxt = 1'b0;
      end
      mbp_pkg::CMD_RD_I:    fr_addr = i_r[AW-1:0];
      mbp_pkg::CMD_RD_J:    fr_addr = j_r[AW-1:0];
      mbp_pkg::CMD_RD_LAST: fr_addr = last_idx[AW-1:0];
      mbp_pkg::CMD_RD_S:    ;
      mbp_pkg::CMD_SCAN: begin
        if (fits && (!best_vld_r || fit < min_fit_r)) begin
          best_vld_nxt = 1'b1;
          min_fit_nxt = fit;
          bl_nxt = rdata_r[4*CB-1:3*CB];
          bt_nxt = rdata_r[3*CB-1:2*CB];
        end
        i_nxt = i_r + NW'(1);
      end
      mbp_pkg::CMD_UNION: begin
        ul_nxt = XW'(bl_r);
        ut_nxt = XW'(bt_r);
        ur_nxt = XW'(bl_r) + XW'(rw_r) + XW'(pad_r);
        ub_nxt = XW'(bt_r) + XW'(rh_r) + XW'(pad_r);
        i_nxt = '0; n_nxt = '0; ok_nxt = 1'b1;
      end
      mbp_pkg::CMD_PASSA: begin
        if (!ovl_rd) begin
          if (full) ok_nxt = 1'b0;
          else begin
            sw_en = 1'b1; sw_data = rdata_r; n_nxt = n_r + NW'(1);
          end
        end
        i_nxt = i_r + NW'(1);
      end
      mbp_pkg::CMD_IRST: i_nxt = '0;
      mbp_pkg::CMD_FLAT: begin
        f_nxt = rdata_r; pc_nxt = 2'd0;
      end
      mbp_pkg::CMD_PIECE: begin
        if (ok_r && stage_en) begin
          if (full) ok_nxt = 1'b0;
          else begin
            sw_en = 1'b1; sw_data = piece; n_nxt = n_r + NW'(1);
          end
        end
        pc_nxt = pc_r + 2'd1;
        if (pc_r == 2'd3) i_nxt = i_r + NW'(1);
      end
      mbp_pkg::CMD_CPINIT: begin
        i_nxt = '0; cnt_nxt = n_r;
      end
      mbp_pkg::CMD_COPY: begin
        fw_en = 1'b1; fw_addr = i_r[AW-1:0]; fw_data = srdata_r;
        i_nxt = i_r + NW'(1);
      end
      mbp_pkg::CMD_PRINIT: i_nxt = '0;
      mbp_pkg::CMD_PR_R: begin
        r_nxt = rdata_r; j_nxt = i_r + NW'(1);
      end
      mbp_pkg::CMD_JINC: j_nxt = j_r + NW'(1);
      mbp_pkg::CMD_SWAP: begin
        fw_en = 1'b1; fw_addr = i_r[AW-1:0]; fw_data = rdata_r;
        cnt_nxt = last_idx;
      end
      mbp_pkg::CMD_KINIT: begin
        k_nxt = i_r + NW'(1); j_nxt = i_r + NW'(1);
      end
      mbp_pkg::CMD_COMPACT: begin
        if (!holds(r_r, rdata_r)) begin
          fw_en = 1'b1; fw_addr = k_r[AW-1:0]; fw_data = rdata_r;
          k_nxt = k_r + NW'(1);
        end
        j_nxt = j_r + NW'(1);
      end
      mbp_pkg::CMD_PRNEXT: begin
        cnt_nxt = k_r; i_nxt = i_r + NW'(1);
      end
      mbp_pkg::CMD_EMIT_NONE, mbp_pkg::CMD_EMIT_OVF: begin
        ovld_nxt = 1'b1; ofound_nxt = 1'b0;
        oovf_nxt = (cmd == mbp_pkg::CMD_EMIT_OVF);
        ox_nxt = '0; oy_nxt = '0;
      end
      mbp_pkg::CMD_EMIT_OK: begin
        ovld_nxt = 1'b1; ofound_nxt = 1'b1; oovf_nxt = 1'b0;
        ox_nxt = CB'(ul_r); oy_nxt = CB'(ut_r);
      end
      default: ;
    endcase
  end

  // free rect table
  always_ff @(posedge clk) begin
    if (fw_en) free_mem[fw_addr] <= fw_data;
    rdata_r <= free_mem[fr_addr];
  end

  // split staging table
  always_ff @(posedge clk) begin
    if (sw_en) scr_mem[sw_addr] <= sw_data;
    srdata_r <= scr_mem[i_r[AW-1:0]];
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      aw_r  <= 15'd1024;
      ah_r  <= 15'd1024;
      pad_r <= 8'd0;
    end else if (cfg_we) begin
      case (cfg_idx)
        mbp_pkg::CFG_ATLAS_W: aw_r  <= cfg_wdata;
        mbp_pkg::CFG_ATLAS_H: ah_r  <= cfg_wdata;
        mbp_pkg::CFG_PAD:     pad_r <= cfg_wdata[mbp_pkg::PW-1:0];
        default: ;
      endcase
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0; n_r <= '0; ok_r <= 1'b1; best_vld_r <= 1'b0; ovld_r <= 1'b0;
    end else begin
      cnt_r <= cnt_nxt; n_r <= n_nxt; ok_r <= ok_nxt;
      best_vld_r <= best_vld_nxt; ovld_r <= ovld_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    i_r <= i_nxt; j_r <= j_nxt; k_r <= k_nxt;
    rw_r <= rw_nxt; rh_r <= rh_nxt; min_fit_r <= min_fit_nxt;
    bl_r <= bl_nxt; bt_r <= bt_nxt;
    ul_r <= ul_nxt; ut_r <= ut_nxt; ur_r <= ur_nxt; ub_r <= ub_nxt;
    f_r <= f_nxt; r_r <= r_nxt; pc_r <= pc_nxt;
    ofound_r <= ofound_nxt; oovf_r <= oovf_nxt; ox_r <= ox_nxt; oy_r <= oy_nxt;
  end

  // status and result
  assign st.i_lt_cnt   = (i_r < cnt_r);
  assign st.j_lt_cnt   = (j_r < cnt_r);
  assign st.ok         = ok_r;
  assign st.best_vld   = best_vld_r;
  assign st.hit        = holds(rdata_r, r_r);
  assign st.last_piece = (pc_r == 2'd3);
  assign st.out_full   = ovld_r;

  assign x_ext     = 32'(ox_r);
  assign y_ext     = 32'(oy_r);
  assign out_vld   = ovld_r;
  assign out_found = ofound_r;
  assign out_ovf   = oovf_r;
  assign out_x     = x_ext[14:0];
  assign out_y     = y_ext[14:0];

  // checks
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= NW'(MAX_FREE)) else $error("free count past table depth");
  a_n_bound: assert property (@(posedge clk) disable iff (!rst_n)
    n_r <= NW'(MAX_FREE)) else $error("staging count past table depth");
  a_emit_free: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd == mbp_pkg::CMD_EMIT_OK || cmd == mbp_pkg::CMD_EMIT_OVF ||
     cmd == mbp_pkg::CMD_EMIT_NONE) |-> !ovld_r)
    else $error("result written over a pending beat");
  a_excl: assert property (@(posedge clk) disable iff (!rst_n)
    ovld_r |-> !(ofound_r && oovf_r)) else $error("found with overflow");

endmodule

`default_nettype wire

// ===== hw/rtl/maxrects_bin_packer_top.sv =====
// ----------------------------------------------------------------------------
// maxrects_bin_packer_top
// Rectangle packer, best short side fit over a table of free rects.
// ----------------------------------------------------------------------------
// One item at a time. A clear runs from its request beat through accept,
// table load and result. An allocate with n free rects runs the fit scan,
// the untouched-rect pass, the split of the overlapped rects, the copy of
// the m rebuilt rects back and the containment prune, each through the one
// read port of the free rect table and its registered read; a full staging
// table ends it early with an overflow result. After reset the INIT state
// loads the whole atlas into the table before the first request beat is
// taken. A result beat waits in an output register until taken.
`default_nettype none

module maxrects_bin_packer_top #(
  parameter int MAX_FREE = 64
) (
  input wire logic  clk,
  input wire logic  rst_n,
  mbp_in_if.sink    in_ch,
  mbp_out_if.source out_ch,
  mbp_cfg_if.sink   cfg_ch
);

  mbp_pkg::cmd_t    cmd;
  mbp_pkg::status_t st;
  logic             in_rdy;

  assign in_ch.ready  = in_rdy;
  assign cfg_ch.ready = 1'b1;

  mbp_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_vld    (in_ch.valid),
    .in_action (in_ch.action),
    .in_rdy    (in_rdy),
    .st        (st),
    .cmd       (cmd)
  );

  mbp_dp #(
    .MAX_FREE (MAX_FREE)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .st        (st),
    .in_req_w  (in_ch.req_width),
    .in_req_h  (in_ch.req_height),
    .cfg_we    (cfg_ch.valid),
    .cfg_idx   (cfg_ch.index),
    .cfg_wdata (cfg_ch.data),
    .out_vld   (out_ch.valid),
    .out_rdy   (out_ch.ready),
    .out_found (out_ch.found),
    .out_x     (out_ch.place_x),
    .out_y     (out_ch.place_y),
    .out_ovf   (out_ch.overflow)
  );

endmodule

`default_nettype wire

// ===== tb/maxrects_bin_packer_top_tb.sv =====
// ----------------------------------------------------------------------------
// maxrects_bin_packer_top_tb
// Self-checking bench for the rectangle packer. A shadow free-rect table
// predicts every allocate and clear. Directed tests cover the corner cases,
// then random allocate/clear streams run under several atlas and pad
// settings. Both channels stall at random.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module maxrects_bin_packer_top_tb;

  localparam int MAX_FREE = 64;
  localparam logic ACT_ALLOC = mbp_pkg::ACT_ALLOC;
  localparam logic ACT_CLEAR = mbp_pkg::ACT_CLEAR;

  typedef struct {
    int unsigned l, t, w, h;
  } rect_t;

  typedef struct packed {
    logic        found;
    logic [14:0] x;
    logic [14:0] y;
    logic        ovf;
  } place_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  mbp_in_if  in_if ();
  mbp_out_if out_if ();
  mbp_cfg_if cfg_if ();

  maxrects_bin_packer_top u_top (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_if),
    .out_ch(out_if),
    .cfg_ch(cfg_if)
  );

  always #5 clk = ~clk;

  // shadow packer state
  int unsigned atlas_w, atlas_h, pad;
  rect_t       free_tab[MAX_FREE];
  rect_t       split_tab[MAX_FREE];
  int          free_n;

  place_t      place_q[$];
  int          err_cnt = 0;
  int          n_items = 0;
  int          n_placed = 0;
  int          n_ovf = 0;
  bit          in_burst = 0;
  bit          out_burst = 0;

  initial begin
    in_if.valid = 1'b0;
    in_if.action = ACT_ALLOC;
    in_if.req_width = '0;
    in_if.req_height = '0;
    out_if.ready = 1'b0;
    cfg_if.valid = 1'b0;
    cfg_if.index = mbp_pkg::CFG_ATLAS_W;
    cfg_if.data = '0;
  end

  // ---------------------------------------------------------------- model
  function automatic bit rect_overlap(rect_t a, rect_t b);
    int unsigned lx, hx, ly, hy;
    lx = (a.l > b.l) ? a.l : b.l;
    hx = ((a.l + a.w) < (b.l + b.w)) ? (a.l + a.w) : (b.l + b.w);
    ly = (a.t > b.t) ? a.t : b.t;
    hy = ((a.t + a.h) < (b.t + b.h)) ? (a.t + a.h) : (b.t + b.h);
    return (lx < hx) && (ly < hy);
  endfunction

  // a holds b
  function automatic bit rect_holds(rect_t a, rect_t b);
    return b.l >= a.l && b.t >= a.t && b.l + b.w <= a.l + a.w &&
           b.t + b.h <= a.t + a.h;
  endfunction

  function automatic void wipe_atlas();
    free_n = 0;
    foreach (free_tab[i]) free_tab[i] = '{0, 0, 0, 0};
    if (atlas_w != 0 && atlas_h != 0) begin
      free_tab[0] = '{0, 0, atlas_w, atlas_h};
      free_n = 1;
    end
  endfunction

  function automatic bit stage_piece(inout int n, input rect_t b);
    if (n >= MAX_FREE) return 1'b0;
    split_tab[n] = b;
    n++;
    return 1'b1;
  endfunction

  // drop every free rect held by another one
  function automatic void prune_held();
    int n, i, j, k;
    rect_t r;
    bit held;
    n = free_n;
    i = 0;
    while (i < n) begin
      r = free_tab[i];
      held = 0;
      for (j = i + 1; j < n; j++)
        if (rect_holds(free_tab[j], r)) begin
          held = 1;
          break;
        end
      if (held) begin
        n--;
        free_tab[i] = free_tab[n];
      end else begin
        k = i + 1;
        for (j = i + 1; j < n; j++)
          if (!rect_holds(r, free_tab[j])) free_tab[k++] = free_tab[j];
        n = k;
        i++;
      end
    end
    free_n = n;
  endfunction

  function automatic place_t pack_alloc(int unsigned rw, int unsigned rh);
    place_t res;
    int best, n;
    int unsigned min_fit, dw, dh, fit, ur, ub, fr, fb;
    bit ok;
    rect_t u, f, p;
    res = '0;
    best = -1;
    min_fit = 0;
    n = 0;
    ok = 1;
    for (int i = 0; i < free_n; i++) begin
      f = free_tab[i];
      if (f.w >= rw && f.h >= rh) begin
        dw = f.w - rw;
        dh = f.h - rh;
        fit = (dw < dh) ? dw : dh;
        if (best < 0 || fit < min_fit) begin
          best = i;
          min_fit = fit;
        end
      end
    end
    if (best < 0) return res;
    u = '{free_tab[best].l, free_tab[best].t, rw + pad, rh + pad};
    ur = u.l + u.w;
    ub = u.t + u.h;
    for (int i = 0; i < free_n && ok; i++)
      if (!rect_overlap(free_tab[i], u)) ok = stage_piece(n, free_tab[i]);
    // split overlapped rects: above, below, left, right
    for (int i = 0; i < free_n && ok; i++) begin
      f = free_tab[i];
      fr = f.l + f.w;
      fb = f.t + f.h;
      if (rect_overlap(f, u)) begin
        if (u.l < fr && ur > f.l) begin
          if (ok && u.t > f.t && u.t < fb) begin
            p = f; p.h = u.t - f.t; ok = stage_piece(n, p);
          end
          if (ok && ub < fb) begin
            p = f; p.t = ub; p.h = fb - ub; ok = stage_piece(n, p);
          end
        end
        if (u.t < fb && ub > f.t) begin
          if (ok && u.l > f.l && u.l < fr) begin
            p = f; p.w = u.l - f.l; ok = stage_piece(n, p);
          end
          if (ok && ur < fr) begin
            p = f; p.l = ur; p.w = fr - ur; ok = stage_piece(n, p);
          end
        end
      end
    end
    if (!ok) begin
      res.ovf = 1'b1;
      return res;
    end
    for (int i = 0; i < n; i++) free_tab[i] = split_tab[i];
    free_n = n;
    prune_held();
    res.found = 1'b1;
    res.x = u.l[14:0];
    res.y = u.t[14:0];
    return res;
  endfunction

  // ---------------------------------------------------------------- drivers
  task automatic send_item(logic act, int unsigned rw, int unsigned rh);
    int gap;
    place_t res;
    gap = in_burst ? 0 : $urandom_range(0, 6);
    if (gap > 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_if.valid <= 1'b1;
    in_if.action <= act;
    in_if.req_width <= rw[14:0];
    in_if.req_height <= rh[14:0];
    do @(posedge clk); while (!in_if.ready);
    if (act == ACT_CLEAR) begin
      wipe_atlas();
      res = '0;
    end else begin
      res = pack_alloc(rw & 32'h7fff, rh & 32'h7fff);
    end
    place_q = {place_q, res};
    n_items++;
  endtask

  // lower valid and let every pending result drain
  task automatic drain_results();
    in_if.valid <= 1'b0;
    @(posedge clk);
    while (place_q.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, int unsigned val);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data <= val[14:0];
    do @(posedge clk); while (!cfg_if.ready);
    cfg_if.valid <= 1'b0;
    case (idx)
      mbp_pkg::CFG_ATLAS_W: atlas_w = val & 32'h7fff;
      mbp_pkg::CFG_ATLAS_H: atlas_h = val & 32'h7fff;
      mbp_pkg::CFG_PAD:     pad = val & 32'hff;
      default: ;
    endcase
    @(posedge clk);
  endtask

  task automatic set_atlas(int unsigned w, int unsigned h, int unsigned pd);
    drain_results();
    write_reg(mbp_pkg::CFG_ATLAS_W, w);
    write_reg(mbp_pkg::CFG_ATLAS_H, h);
    write_reg(mbp_pkg::CFG_PAD, pd);
  endtask

  // ---------------------------------------------------------------- checker
  task automatic report_mismatch(string what, int got, int want);
    $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $time);
    err_cnt++;
  endtask

  initial begin
    int stall;
    place_t want;
    @(posedge rst_n);
    forever begin
      if (($urandom_range(0, 40)) == 0) out_burst = ~out_burst;
      stall = out_burst ? 0 : $urandom_range(0, 6);
      if (stall > 0) begin
        out_if.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_if.ready <= 1'b1;
      do @(posedge clk); while (!out_if.valid);
      // result beat taken at this edge
      if (place_q.size() == 0) begin
        report_mismatch("unexpected beat, found", out_if.found, -1);
      end else begin
        want = place_q.pop_front();
        if (out_if.found !== want.found) report_mismatch("found", out_if.found, want.found);
        if (out_if.place_x !== want.x) report_mismatch("place_x", out_if.place_x, want.x);
        if (out_if.place_y !== want.y) report_mismatch("place_y", out_if.place_y, want.y);
        if (out_if.overflow !== want.ovf)
          report_mismatch("overflow", out_if.overflow, want.ovf);
        if (want.found) n_placed++;
        if (want.ovf) n_ovf++;
      end
    end
  end

  // ---------------------------------------------------------------- tests
  task automatic test_basic_fit();
    send_item(ACT_ALLOC, 0, 0);          // zero size, nothing cut
    send_item(ACT_ALLOC, 100, 50);
    send_item(ACT_ALLOC, 1025, 1);       // no fitting rect
    send_item(ACT_ALLOC, 16384, 16384);
    send_item(ACT_ALLOC, 32767, 0);
    send_item(ACT_ALLOC, 200, 300);
    send_item(ACT_ALLOC, 50, 100);       // ties among pieces
    send_item(ACT_CLEAR, 0, 0);
    send_item(ACT_ALLOC, 1024, 1024);    // whole atlas
    send_item(ACT_ALLOC, 1, 1);          // table empty now
    send_item(ACT_CLEAR, 32767, 32767);
  endtask

  task automatic test_pad_and_size();
    set_atlas(16384, 16384, 255);
    send_item(ACT_ALLOC, 0, 0);          // still at old 1024 atlas
    send_item(ACT_CLEAR, 0, 0);
    send_item(ACT_ALLOC, 16384, 16384);
    send_item(ACT_CLEAR, 0, 0);
    send_item(ACT_ALLOC, 0, 0);          // zero size with padding cuts
    send_item(ACT_ALLOC, 16129, 5);
    send_item(ACT_ALLOC, 10, 10);
  endtask

  task automatic test_zero_atlas();
    set_atlas(0, 512, 0);
    send_item(ACT_CLEAR, 0, 0);
    send_item(ACT_ALLOC, 0, 0);
    set_atlas(512, 0, 3);
    send_item(ACT_CLEAR, 0, 0);
    send_item(ACT_ALLOC, 0, 0);
  endtask

  // random allocate and clear stream under one atlas setting
  task automatic test_random_stream(int unsigned w, int unsigned h, int unsigned pd,
                                    int count, int clear_odds);
    int unsigned lim;
    set_atlas(w, h, pd);
    send_item(ACT_CLEAR, 0, 0);
    lim = (w > h ? w : h) / 6 + 1;
    for (int k = 0; k < count; k++) begin
      if (($urandom_range(0, 30)) == 0) in_burst = ~in_burst;
      if (clear_odds != 0 && $urandom_range(1, clear_odds) == 1)
        send_item(ACT_CLEAR, $urandom_range(0, 32767), $urandom_range(0, 32767));
      else if ($urandom_range(0, 9) == 0)
        send_item(ACT_ALLOC, $urandom_range(0, 16384), $urandom_range(0, 16384));
      else
        send_item(ACT_ALLOC, $urandom_range(0, lim), $urandom_range(0, lim));
    end
  endtask

  // long run of small rects without clears, to fill the free table
  task automatic test_table_fill();
    test_random_stream(16384, 16384, $urandom_range(0, 8), 70, 0);
  endtask

  initial begin
    atlas_w = 1024;
    atlas_h = 1024;
    pad = 0;
    wipe_atlas();
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    test_basic_fit();
    test_pad_and_size();
    test_zero_atlas();
    test_table_fill();
    test_random_stream(1024, 1024, 0, 50, 12);
    test_random_stream($urandom_range(1, 16384), $urandom_range(1, 16384),
                       $urandom_range(0, 255), 50, 10);
    test_random_stream(64, 48, 1, 30, 8);
    test_random_stream(16384, 16384, 255, 30, 10);
    test_random_stream($urandom_range(1, 4096), $urandom_range(1, 4096),
                       $urandom_range(0, 16), 50, 14);
    drain_results();
    $display("covered %0d items: %0d placed, %0d refused on a full table",
             n_items, n_placed, n_ovf);
    if (err_cnt == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  initial begin
    #(200_000_000);
    $display("timeout with %0d results outstanding", place_q.size());
    $display("RESULT: ERROR");
    $finish;
  end

endmodule
